>>> rtl/rgfd_pkg.sv
`default_nettype none
package rgfd_pkg;

   // Update kinds carried on rsp_update_kind
   localparam logic [2:0] KIND_PI  = 3'd0;
   localparam logic [2:0] KIND_PTY = 3'd1;
   localparam logic [2:0] KIND_TP  = 3'd2;
   localparam logic [2:0] KIND_TA  = 3'd3;
   localparam logic [2:0] KIND_AF  = 3'd4;
   localparam logic [2:0] KIND_PS  = 3'd5;
   localparam logic [2:0] KIND_RT  = 3'd6;

   // Group type codes: type number times two plus the version bit
   localparam logic [4:0] GROUP_0A = 5'd0;
   localparam logic [4:0] GROUP_0B = 5'd1;
   localparam logic [4:0] GROUP_2A = 5'd4;
   localparam logic [4:0] GROUP_2B = 5'd5;

   // Configuration register indexes
   localparam logic CSR_STRICT_LIMIT = 1'b0;
   localparam logic CSR_LOOSE_LIMIT  = 1'b1;

   localparam logic [1:0] STRICT_LIMIT_RESET = 2'd1;
   localparam logic [1:0] LOOSE_LIMIT_RESET  = 2'd2;

   localparam int NUM_STEPS   = 9;
   localparam int QUEUE_DEPTH = 2;

   // Emission steps, in the order the updates leave the block
   typedef enum logic [3:0] {
      STEP_PI_A = 4'd0,
      STEP_PI_C = 4'd1,
      STEP_PTY  = 4'd2,
      STEP_TP   = 4'd3,
      STEP_AF   = 4'd4,
      STEP_TA   = 4'd5,
      STEP_PS0  = 4'd6,
      STEP_PS1  = 4'd7,
      STEP_RT   = 4'd8
   } step_type;

   // A classified group: which updates it yields and the blocks they draw on
   typedef struct packed {
      logic [NUM_STEPS-1:0] steps;
      logic [15:0]          block_a;
      logic [15:0]          block_b;
      logic [15:0]          block_c;
      logic [15:0]          block_d;
   } desc_type;

endpackage
`default_nettype wire

>>> rtl/rgfd_front.sv
`default_nettype none
module rgfd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_status_ready,
   input  wire logic              req_data_ready,
   input  wire logic [15:0]       req_block_a,
   input  wire logic [15:0]       req_block_b,
   input  wire logic [15:0]       req_block_c,
   input  wire logic [15:0]       req_block_d,
   input  wire logic [7:0]        req_error_levels,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [1:0]        csr_wdata,
   input  wire logic              q_full,
   output logic                   q_push,
   output rgfd_pkg::desc_type     q_desc
);

   logic [1:0] strict_limit_ff;
   logic [1:0] strict_limit_in;
   logic [1:0] loose_limit_ff;
   logic [1:0] loose_limit_in;

   logic       keep;
   logic       ok_a;
   logic       ok_c;
   logic       ok_d;
   logic       is_0x;
   logic [4:0] group;

   always_comb begin
      strict_limit_in = strict_limit_ff;
      loose_limit_in  = loose_limit_ff;
      if (csr_we) begin
         case (csr_index)
            rgfd_pkg::CSR_STRICT_LIMIT: strict_limit_in = csr_wdata;
            rgfd_pkg::CSR_LOOSE_LIMIT:  loose_limit_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_limit_ff <= rgfd_pkg::STRICT_LIMIT_RESET;
         loose_limit_ff  <= rgfd_pkg::LOOSE_LIMIT_RESET;
      end else begin
         strict_limit_ff <= strict_limit_in;
         loose_limit_ff  <= loose_limit_in;
      end
   end

   // Dropped groups are still taken from the channel; they simply never enter the queue.
   always_comb begin
      group = req_block_b[15:11];
      keep  = req_status_ready && req_data_ready &&
              (req_error_levels[5:4] <= strict_limit_ff);
      ok_a  = req_error_levels[7:6] <= loose_limit_ff;
      ok_c  = req_error_levels[3:2] <= loose_limit_ff;
      ok_d  = req_error_levels[1:0] <= loose_limit_ff;
      is_0x = (group == rgfd_pkg::GROUP_0A) || (group == rgfd_pkg::GROUP_0B);

      q_desc.block_a = req_block_a;
      q_desc.block_b = req_block_b;
      q_desc.block_c = req_block_c;
      q_desc.block_d = req_block_d;
      q_desc.steps   = '0;
      q_desc.steps[rgfd_pkg::STEP_PI_A] = ok_a;
      q_desc.steps[rgfd_pkg::STEP_PI_C] = group[0] && ok_c;
      q_desc.steps[rgfd_pkg::STEP_PTY]  = 1'b1;
      q_desc.steps[rgfd_pkg::STEP_TP]   = 1'b1;
      q_desc.steps[rgfd_pkg::STEP_AF]   = (group == rgfd_pkg::GROUP_0A) && ok_c;
      q_desc.steps[rgfd_pkg::STEP_TA]   = is_0x;
      q_desc.steps[rgfd_pkg::STEP_PS0]  = is_0x && ok_d;
      q_desc.steps[rgfd_pkg::STEP_PS1]  = is_0x && ok_d;
      q_desc.steps[rgfd_pkg::STEP_RT]   =
         ((group == rgfd_pkg::GROUP_2A) && ok_c && ok_d) ||
         ((group == rgfd_pkg::GROUP_2B) && ok_d);

      req_ready = !q_full;
      q_push    = req_valid && req_ready && keep;
   end

endmodule
`default_nettype wire

>>> rtl/rgfd_queue.sv
`default_nettype none
module rgfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rgfd_pkg::desc_type push_desc,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output rgfd_pkg::desc_type      pop_desc
);

   rgfd_pkg::desc_type entry_ff [rgfd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      full      = count_ff == 2'(rgfd_pkg::QUEUE_DEPTH);
      pop_valid = count_ff != 2'd0;
      pop_desc  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("queue read while empty");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(rgfd_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/rgfd_back.sv
`default_nettype none
module rgfd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire rgfd_pkg::desc_type q_desc,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_update_kind,
   output logic [3:0]              rsp_position,
   output logic [31:0]             rsp_payload,
   output logic [2:0]              rsp_char_count,
   output logic                    rsp_text_ab_flag,
   output logic                    rsp_last
);

   rgfd_pkg::desc_type desc_ff;
   rgfd_pkg::desc_type desc_in;
   logic [rgfd_pkg::NUM_STEPS-1:0] steps_ff;
   logic [rgfd_pkg::NUM_STEPS-1:0] steps_in;
   logic [rgfd_pkg::NUM_STEPS-1:0] lowest;
   logic [rgfd_pkg::NUM_STEPS-1:0] rest;
   rgfd_pkg::step_type             sel;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  kind_ff;
   logic [2:0]  kind_in;
   logic [3:0]  position_ff;
   logic [3:0]  position_in;
   logic [31:0] payload_ff;
   logic [31:0] payload_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic        ab_ff;
   logic        ab_in;
   logic        last_ff;
   logic        last_in;

   logic        advance;
   logic        emit;
   logic [15:0] b;

   // Steps go lowest bit first, one update per cycle while rsp_ready is high.
   always_comb begin
      sel = rgfd_pkg::STEP_PI_A;
      for (int i = rgfd_pkg::NUM_STEPS - 1; i >= 0; i--) begin
         if (steps_ff[i]) begin
            sel = rgfd_pkg::step_type'(4'(i));
         end
      end
   end

   always_comb begin
      b       = desc_ff.block_b;
      lowest  = steps_ff & (~steps_ff + 1'b1);
      rest    = steps_ff & ~lowest;
      advance = !rsp_valid_ff || rsp_ready;
      emit    = advance && (steps_ff != '0);

      kind_in     = rgfd_pkg::KIND_PTY;
      position_in = 4'd0;
      payload_in  = 32'd0;
      count_in    = 3'd0;
      ab_in       = 1'b0;
      last_in     = rest == '0;
      case (sel)
         rgfd_pkg::STEP_PI_A: begin
            kind_in    = rgfd_pkg::KIND_PI;
            payload_in = {16'd0, desc_ff.block_a};
         end
         rgfd_pkg::STEP_PI_C: begin
            kind_in    = rgfd_pkg::KIND_PI;
            payload_in = {16'd0, desc_ff.block_c};
         end
         rgfd_pkg::STEP_PTY: begin
            kind_in    = rgfd_pkg::KIND_PTY;
            payload_in = {27'd0, b[9:5]};
         end
         rgfd_pkg::STEP_TP: begin
            kind_in    = rgfd_pkg::KIND_TP;
            payload_in = {31'd0, b[10]};
         end
         rgfd_pkg::STEP_AF: begin
            kind_in    = rgfd_pkg::KIND_AF;
            payload_in = {16'd0, desc_ff.block_c};
         end
         rgfd_pkg::STEP_TA: begin
            kind_in    = rgfd_pkg::KIND_TA;
            payload_in = {31'd0, b[4]};
         end
         rgfd_pkg::STEP_PS0: begin
            kind_in     = rgfd_pkg::KIND_PS;
            position_in = {1'b0, b[1:0], 1'b0};
            payload_in  = {24'd0, desc_ff.block_d[15:8]};
         end
         rgfd_pkg::STEP_PS1: begin
            kind_in     = rgfd_pkg::KIND_PS;
            position_in = {1'b0, b[1:0], 1'b1};
            payload_in  = {24'd0, desc_ff.block_d[7:0]};
         end
         rgfd_pkg::STEP_RT: begin
            kind_in     = rgfd_pkg::KIND_RT;
            position_in = b[3:0];
            ab_in       = b[4];
            // Version A carries four characters, version B only the two of block D.
            if (!b[11]) begin
               payload_in = {desc_ff.block_c, desc_ff.block_d};
               count_in   = 3'd4;
            end else begin
               payload_in = {desc_ff.block_d, 16'd0};
               count_in   = 3'd2;
            end
         end
         default: ;
      endcase

      steps_in = emit ? rest : steps_ff;
      desc_in  = desc_ff;
      q_pop    = q_valid && ((steps_ff == '0) || (emit && (rest == '0)));
      if (q_pop) begin
         steps_in = q_desc.steps;
         desc_in  = q_desc;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (emit) begin
         kind_ff     <= kind_in;
         position_ff <= position_in;
         payload_ff  <= payload_in;
         count_ff    <= count_in;
         ab_ff       <= ab_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_update_kind  = kind_ff;
   assign rsp_position     = position_ff;
   assign rsp_payload      = payload_ff;
   assign rsp_char_count   = count_ff;
   assign rsp_text_ab_flag = ab_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_pi_never_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == rgfd_pkg::KIND_PI)) |-> !last_ff)
      else $error("PI update marked as the last of its group");
   a_even_ps_never_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == rgfd_pkg::KIND_PS) && !position_ff[0]) |-> !last_ff)
      else $error("first PS character marked as the last of its group");
   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (steps_ff != '0)) |-> (emit && (rest == '0)))
      else $error("new group loaded before the current one finished");
`endif

endmodule
`default_nettype wire

>>> rtl/rds_group_field_decoder_core.sv
`default_nettype none
// Channel   Direction  Handshake             Moves
// req_      in         req_valid/req_ready   one RDS group per transaction
// rsp_      out        rsp_valid/rsp_ready   one field update per transaction
// csr_      in         csr_we                one limit register write
//
// A kept group yields two to seven updates, one per cycle when rsp_ready is high;
// the output register sequencer in the back end sets that rate.
// Dropped groups are still taken from the channel but produce nothing.
// A two-entry queue sits between classification and emission, so new groups are
// taken while earlier ones are still being emitted; req_ready falls only when it is full.
// Reset is synchronous and restores the limits to strict 1 and loose 2.
module rds_group_field_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_status_ready,
   input  wire logic        req_data_ready,
   input  wire logic [15:0] req_block_a,
   input  wire logic [15:0] req_block_b,
   input  wire logic [15:0] req_block_c,
   input  wire logic [15:0] req_block_d,
   input  wire logic [7:0]  req_error_levels,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_update_kind,
   output logic [3:0]       rsp_position,
   output logic [31:0]      rsp_payload,
   output logic [2:0]       rsp_char_count,
   output logic             rsp_text_ab_flag,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [1:0]  csr_wdata
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   rgfd_pkg::desc_type push_desc;
   rgfd_pkg::desc_type pop_desc;

   rgfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_status_ready (req_status_ready),
      .req_data_ready   (req_data_ready),
      .req_block_a      (req_block_a),
      .req_block_b      (req_block_b),
      .req_block_c      (req_block_c),
      .req_block_d      (req_block_d),
      .req_error_levels (req_error_levels),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (push_desc)
   );

   rgfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (pop_desc)
   );

   rgfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_desc           (pop_desc),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_update_kind  (rsp_update_kind),
      .rsp_position     (rsp_position),
      .rsp_payload      (rsp_payload),
      .rsp_char_count   (rsp_char_count),
      .rsp_text_ab_flag (rsp_text_ab_flag),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

>>> dv/tb_rds_group_field_decoder_core.sv
`timescale 1ns / 1ps

module tb_rds_group_field_decoder_core;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int GROUPS_PER_PHASE = 51;

   typedef struct packed {
      logic        status_ready;
      logic        data_ready;
      logic [15:0] block_a;
      logic [15:0] block_b;
      logic [15:0] block_c;
      logic [15:0] block_d;
      logic [7:0]  error_levels;
   } rds_group_type;

   typedef struct packed {
      logic [2:0]  update_kind;
      logic [3:0]  position;
      logic [31:0] payload;
      logic [2:0]  char_count;
      logic        text_ab_flag;
      logic        last;
   } field_update_type;

   class rds_update_board;
      field_update_type awaited_updates[$];
      logic [1:0]       strict_limit;
      logic [1:0]       loose_limit;
      int               mismatches;

      function new();
         strict_limit = rgfd_pkg::STRICT_LIMIT_RESET;
         loose_limit  = rgfd_pkg::LOOSE_LIMIT_RESET;
         mismatches   = 0;
      endfunction

      function void set_limit(logic index, logic [1:0] value);
         if (index == rgfd_pkg::CSR_STRICT_LIMIT) begin
            strict_limit = value;
         end else begin
            loose_limit = value;
         end
      endfunction

      function void stage(logic [2:0] kind, logic [3:0] pos, logic [31:0] value,
                          logic [2:0] count, logic ab);
         awaited_updates.push_back({kind, pos, value, count, ab, 1'b0});
      endfunction

      // Works out the updates that one accepted group yields and queues them.
      function int predict_group(rds_group_type g);
         logic [1:0] lv_a, lv_b, lv_c, lv_d;
         logic       use_a, use_c, use_d, ab;
         logic [4:0] grp;
         logic [3:0] ps_pos;
         int         first;
         first = awaited_updates.size();
         lv_a  = g.error_levels[7:6];
         lv_b  = g.error_levels[5:4];
         lv_c  = g.error_levels[3:2];
         lv_d  = g.error_levels[1:0];
         if (!g.status_ready || !g.data_ready || lv_b > strict_limit) begin
            return 0;
         end
         use_a  = lv_a <= loose_limit;
         use_c  = lv_c <= loose_limit;
         use_d  = lv_d <= loose_limit;
         grp    = g.block_b[15:11];
         ab     = g.block_b[4];
         ps_pos = {1'b0, g.block_b[1:0], 1'b0};
         if (use_a) begin
            stage(rgfd_pkg::KIND_PI, 4'd0, {16'd0, g.block_a}, 3'd0, 1'b0);
         end
         if (grp[0] && use_c) begin
            stage(rgfd_pkg::KIND_PI, 4'd0, {16'd0, g.block_c}, 3'd0, 1'b0);
         end
         stage(rgfd_pkg::KIND_PTY, 4'd0, {27'd0, g.block_b[9:5]}, 3'd0, 1'b0);
         stage(rgfd_pkg::KIND_TP, 4'd0, {31'd0, g.block_b[10]}, 3'd0, 1'b0);
         case (grp)
            rgfd_pkg::GROUP_0A, rgfd_pkg::GROUP_0B: begin
               if (grp == rgfd_pkg::GROUP_0A && use_c) begin
                  stage(rgfd_pkg::KIND_AF, 4'd0, {16'd0, g.block_c}, 3'd0, 1'b0);
               end
               stage(rgfd_pkg::KIND_TA, 4'd0, {31'd0, ab}, 3'd0, 1'b0);
               if (use_d) begin
                  stage(rgfd_pkg::KIND_PS, ps_pos, {24'd0, g.block_d[15:8]}, 3'd0, 1'b0);
                  stage(rgfd_pkg::KIND_PS, ps_pos + 4'd1, {24'd0, g.block_d[7:0]},
                        3'd0, 1'b0);
               end
            end
            rgfd_pkg::GROUP_2A: begin
               if (use_c && use_d) begin
                  stage(rgfd_pkg::KIND_RT, g.block_b[3:0], {g.block_c, g.block_d}, 3'd4, ab);
               end
            end
            rgfd_pkg::GROUP_2B: begin
               if (use_d) begin
                  stage(rgfd_pkg::KIND_RT, g.block_b[3:0], {g.block_d, 16'd0}, 3'd2, ab);
               end
            end
            default: begin
            end
         endcase
         awaited_updates[awaited_updates.size()-1].last = 1'b1;
         return awaited_updates.size() - first;
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: %s", $time, msg);
         mismatches++;
      endtask

      task check_update(field_update_type got);
         field_update_type want;
         string            diff;
         if (awaited_updates.size() == 0) begin
            report_mismatch($sformatf("update with nothing awaited: %h", got));
            return;
         end
         want = awaited_updates.pop_front();
         diff = "";
         if (got.update_kind  !== want.update_kind)  diff = {diff, " update_kind"};
         if (got.position     !== want.position)     diff = {diff, " position"};
         if (got.payload      !== want.payload)      diff = {diff, " payload"};
         if (got.char_count   !== want.char_count)   diff = {diff, " char_count"};
         if (got.text_ab_flag !== want.text_ab_flag) diff = {diff, " text_ab_flag"};
         if (got.last         !== want.last)         diff = {diff, " last"};
         if (diff != "") begin
            report_mismatch($sformatf("wrong%s: got %h, want %h", diff, got, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_status_ready;
   logic        req_data_ready;
   logic [15:0] req_block_a;
   logic [15:0] req_block_b;
   logic [15:0] req_block_c;
   logic [15:0] req_block_d;
   logic [7:0]  req_error_levels;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_update_kind;
   logic [3:0]  rsp_position;
   logic [31:0] rsp_payload;
   logic [2:0]  rsp_char_count;
   logic        rsp_text_ab_flag;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [1:0]  csr_wdata;

   rds_update_board board;
   int          idle_cycles = 0;
   bit          req_steady  = 1'b0;
   bit          rsp_steady  = 1'b0;

   rds_group_field_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_status_ready (req_status_ready),
      .req_data_ready   (req_data_ready),
      .req_block_a      (req_block_a),
      .req_block_b      (req_block_b),
      .req_block_c      (req_block_c),
      .req_block_d      (req_block_d),
      .req_error_levels (req_error_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_update_kind  (rsp_update_kind),
      .rsp_position     (rsp_position),
      .rsp_payload      (rsp_payload),
      .rsp_char_count   (rsp_char_count),
      .rsp_text_ab_flag (rsp_text_ab_flag),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] block_b_of(logic [4:0] grp, logic tp, logic [4:0] pty,
                                              logic ab, logic [3:0] addr);
      return {grp, tp, pty, ab, addr};
   endfunction

   function automatic rds_group_type mk(logic sr, logic dr, logic [15:0] a, logic [15:0] b,
                                        logic [15:0] c, logic [15:0] d, logic [7:0] lv);
      return {sr, dr, a, b, c, d, lv};
   endfunction

   function automatic rds_group_type rand_group();
      rds_group_type g;
      logic [4:0]    grp;
      int            pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1:    grp = rgfd_pkg::GROUP_0A;
         2, 3:    grp = rgfd_pkg::GROUP_0B;
         4, 5:    grp = rgfd_pkg::GROUP_2A;
         6, 7:    grp = rgfd_pkg::GROUP_2B;
         default: grp = 5'($urandom_range(0, 31));
      endcase
      g.status_ready = $urandom_range(0, 15) != 0;
      g.data_ready   = $urandom_range(0, 15) != 0;
      g.block_a      = 16'($urandom);
      g.block_b      = {grp, 11'($urandom)};
      g.block_c      = 16'($urandom);
      g.block_d      = 16'($urandom);
      g.error_levels = 8'($urandom);
      // Keep most levels low so that most groups survive the block B limit.
      if ($urandom_range(0, 2) != 0) g.error_levels = g.error_levels & 8'h55;
      return g;
   endfunction

   task automatic send_group(rds_group_type g);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_status_ready <= g.status_ready;
      req_data_ready   <= g.data_ready;
      req_block_a      <= g.block_a;
      req_block_b      <= g.block_b;
      req_block_c      <= g.block_c;
      req_block_d      <= g.block_d;
      req_error_levels <= g.error_levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(board.predict_group(g));
      @(negedge clock);
   endtask

   // A dropped group may still be in flight when the last update has left.
   task automatic drain();
      while (board.awaited_updates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limits(logic [1:0] strict_value, logic [1:0] loose_value);
      csr_we    <= 1'b1;
      csr_index <= rgfd_pkg::CSR_STRICT_LIMIT;
      csr_wdata <= strict_value;
      board.set_limit(rgfd_pkg::CSR_STRICT_LIMIT, strict_value);
      @(negedge clock);
      csr_index <= rgfd_pkg::CSR_LOOSE_LIMIT;
      csr_wdata <= loose_value;
      board.set_limit(rgfd_pkg::CSR_LOOSE_LIMIT, loose_value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         int burst;
         int stall;
         burst = $urandom_range(1, 30);
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (burst - 1) @(negedge clock);
         if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : pick_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_update({rsp_update_kind, rsp_position, rsp_payload,
                             rsp_char_count, rsp_text_ab_flag, rsp_last});
      end
   end

   // Ends the run when neither channel has completed a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [1:0] strict_set [7];
      logic [1:0] loose_set  [7];
      strict_set = '{2'd0, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0};
      loose_set  = '{2'd0, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
      board            = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_status_ready = 1'b0;
      req_data_ready   = 1'b0;
      req_block_a      = '0;
      req_block_b      = '0;
      req_block_c      = '0;
      req_block_d      = '0;
      req_error_levels = '0;
      csr_we           = 1'b0;
      csr_index        = rgfd_pkg::CSR_STRICT_LIMIT;
      csr_wdata        = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed groups under the reset limits, strict 1 and loose 2.
      send_group(mk(1, 1, 16'hC0DE, block_b_of(rgfd_pkg::GROUP_0A, 1, 5'h1F, 1, 4'h0),
                    16'hE0A1, 16'h4142, 8'h00));
      send_group(mk(1, 1, 16'h1234, block_b_of(rgfd_pkg::GROUP_0A, 0, 5'h00, 0, 4'hF),
                    16'h0000, 16'hFFFF, 8'h00));
      send_group(mk(1, 1, 16'h5A5A, block_b_of(rgfd_pkg::GROUP_0A, 1, 5'h0C, 0, 4'h1),
                    16'hAAAA, 16'h5555, 8'h0F));
      send_group(mk(1, 1, 16'hD3C1, block_b_of(rgfd_pkg::GROUP_0B, 1, 5'h0A, 0, 4'h2),
                    16'hD3C1, 16'h5253, 8'h00));
      send_group(mk(1, 1, 16'hFFFF, block_b_of(rgfd_pkg::GROUP_0B, 0, 5'h15, 1, 4'h3),
                    16'h8001, 16'h2020, 8'hC0));
      send_group(mk(1, 1, 16'h0001, block_b_of(rgfd_pkg::GROUP_0B, 1, 5'h01, 1, 4'h0),
                    16'h7FFE, 16'h3031, 8'h0C));
      send_group(mk(1, 1, 16'h2BAD, block_b_of(rgfd_pkg::GROUP_2A, 0, 5'h03, 1, 4'hF),
                    16'h4865, 16'h6C6F, 8'h00));
      send_group(mk(1, 1, 16'h2BAD, block_b_of(rgfd_pkg::GROUP_2A, 1, 5'h03, 0, 4'h7),
                    16'h4865, 16'h6C6F, 8'h0C));
      send_group(mk(1, 1, 16'h2BAD, block_b_of(rgfd_pkg::GROUP_2A, 1, 5'h03, 0, 4'h8),
                    16'h4865, 16'h6C6F, 8'h03));
      send_group(mk(1, 1, 16'h9E01, block_b_of(rgfd_pkg::GROUP_2B, 1, 5'h11, 0, 4'h0),
                    16'h9E01, 16'h5859, 8'h1A));
      send_group(mk(1, 1, 16'h9E01, block_b_of(rgfd_pkg::GROUP_2B, 0, 5'h11, 1, 4'hC),
                    16'h9E01, 16'h5859, 8'h13));
      // Clock-time and other types yield only PI, PTY and TP.
      send_group(mk(1, 1, 16'h4A4A, block_b_of(5'd8, 1, 5'h07, 1, 4'h5),
                    16'hCAFE, 16'hBEEF, 8'h00));
      send_group(mk(1, 1, 16'h0F0F, block_b_of(5'd31, 0, 5'h1E, 0, 4'hA),
                    16'hF0F0, 16'h0FF0, 8'h00));
      send_group(mk(1, 1, 16'h0303, block_b_of(5'd3, 1, 5'h02, 1, 4'h1),
                    16'h1111, 16'h2222, 8'h04));
      // Groups that are dropped outright, mixed with edge cases that are kept.
      send_group(mk(0, 1, 16'h1111, block_b_of(rgfd_pkg::GROUP_0A, 1, 5'h01, 1, 4'h1),
                    16'h2222, 16'h3333, 8'h00));
      send_group(mk(1, 0, 16'h1111, block_b_of(rgfd_pkg::GROUP_2A, 1, 5'h01, 1, 4'h1),
                    16'h2222, 16'h3333, 8'h00));
      send_group(mk(0, 0, 16'h1111, block_b_of(rgfd_pkg::GROUP_0B, 1, 5'h01, 1, 4'h1),
                    16'h2222, 16'h3333, 8'h00));
      send_group(mk(1, 1, 16'h7777, block_b_of(rgfd_pkg::GROUP_0A, 1, 5'h09, 1, 4'h2),
                    16'h8888, 16'h9999, 8'h20));
      send_group(mk(1, 1, 16'h7777, block_b_of(rgfd_pkg::GROUP_0A, 1, 5'h09, 1, 4'h2),
                    16'h8888, 16'h9999, 8'h10));
      send_group(mk(1, 1, 16'h7777, block_b_of(rgfd_pkg::GROUP_2B, 1, 5'h09, 1, 4'h2),
                    16'h8888, 16'h9999, 8'h30));
      send_group(mk(1, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
      send_group(mk(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_group(mk(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));

      for (int p = 0; p < 7; p++) begin
         req_valid <= 1'b0;
         drain();
         if (p == 6) begin
            write_limits(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         end else begin
            write_limits(strict_set[p], loose_set[p]);
         end
         for (int k = 0; k < GROUPS_PER_PHASE; k++) begin
            if ($urandom_range(0, 47) == 0) req_steady = !req_steady;
            send_group(rand_group());
         end
      end

      req_valid <= 1'b0;
      while (board.awaited_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rgfd_pkg.sv
rtl/rgfd_front.sv
rtl/rgfd_queue.sv
rtl/rgfd_back.sv
rtl/rds_group_field_decoder_core.sv
dv/tb_rds_group_field_decoder_core.sv
